>>> design/sawbc_pkg.sv
// Shared types and constants of the set-associative write-back cache.
// Holds the transaction structs and the controller/datapath command and status structs.
// No dependencies.
package sawbc_pkg;

  localparam int unsigned SETS_DEFAULT   = 64;
  localparam int unsigned WAYS_DEFAULT   = 4;
  localparam int unsigned WORDS_PER_LINE = 16;
  localparam int unsigned WORD_IDX_W     = 4;
  localparam int unsigned BLK_W          = 26;
  localparam int unsigned BLK_LSB        = 6;
  localparam int unsigned WORD_LSB       = 2;
  localparam logic [15:0] SEED_RESET     = 16'd44257;
  localparam logic [15:0] LFSR_TAPS      = 16'hB400;

  // Input command codes.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FILL  = 2'd2;

  // Result kind codes.
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WDONE = 2'd1;
  localparam logic [1:0] KIND_WB    = 2'd2;
  localparam logic [1:0] KIND_FREQ  = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [31:0] write_mask;
    logic [31:0] fill_data;
  } cache_in_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [31:0]      data;
    logic [BLK_W-1:0] block_number;
    logic [3:0]       word_index;
    logic             last;
  } cache_out_t;

  typedef enum logic [2:0] {
    EMIT_NONE  = 3'd0,
    EMIT_READ  = 3'd1,
    EMIT_WDONE = 3'd2,
    EMIT_WB    = 3'd3,
    EMIT_FREQ  = 3'd4
  } emit_e;

  typedef struct packed {
    logic  clear_step;
    logic  capture_acc;
    logic  capture_fill;
    logic  set_start;
    logic  vmod_start;
    logic  take_inv;
    logic  take_mod;
    logic  meta_rd;
    logic  meta_wr_evict;
    logic  meta_wr_dirty;
    logic  meta_wr_fill;
    logic  data_rd_hit;
    logic  data_rd_wb;
    logic  data_rd_pend;
    logic  data_wr_fill;
    logic  data_wr_merge;
    logic  wb_inc;
    logic  fill_inc;
    logic  start_fill;
    logic  end_fill;
    emit_e emit;
  } cmd_t;

  typedef struct packed {
    logic in_access;
    logic in_fill;
    logic awaiting;
    logic set_done;
    logic vmod_done;
    logic hit;
    logic any_invalid;
    logic victim_dirty;
    logic wb_last;
    logic fill_last;
    logic clear_last;
    logic out_free;
    logic acc_write;
  } sts_t;

endpackage

>>> design/set_assoc_writeback_cache.sv
// Top level of the set-associative write-back, write-allocate cache.
// Depends on sawbc_pkg, sawbc_ctrl and sawbc_dp.
//
// Usage: the input channel carries read, masked-write and fill-word transactions;
// the output channel returns read data, write done, write-back words and fill
// requests. Both use valid/stall. One transaction is worked on at a time: the
// input stalls until the controller is back in its idle state.
// Steps: the set index is the low bits of the block number when SETS is a power
// of two, else it comes from a reciprocal multiply, then a subtract. A hit then
// reads the tag row, then the data word, and returns its result. A miss takes the
// first invalid way, or else a random victim from the LFSR modulo WAYS, sends each
// word of a dirty victim as a write-back, and then the fill request. Each fill
// word is written into the line; after the last one the tag and state row is
// updated and the completing result is returned.
// After reset the tag and state memories are cleared set by set, during
// which the input stalls; a seed write is taken at any time and reloads the
// victim LFSR. When the receiver stalls, the output register holds its result
// and the controller waits before producing the next one.
module set_assoc_writeback_cache #(
  parameter int unsigned SETS = sawbc_pkg::SETS_DEFAULT,
  parameter int unsigned WAYS = sawbc_pkg::WAYS_DEFAULT
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  sawbc_pkg::cache_in_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output sawbc_pkg::cache_out_t out_data_o,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i
);
  import sawbc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller.
  sawbc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath.
  sawbc_dp #(.SETS(SETS), .WAYS(WAYS)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

>>> design/sawbc_mod.sv
// Remainder of an unsigned value by a constant divisor.
// Power-of-two divisors take the low bits; others go through a reciprocal
// multiply and a subtract. Depends on nothing beyond its parameters.
module sawbc_mod #(
  parameter int unsigned W   = 26,
  parameter int unsigned DIV = 64,
  parameter int unsigned RW  = (DIV > 1) ? $clog2(DIV) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [W-1:0]  value_i,
  output logic          done_o,
  output logic [RW-1:0] rem_o
);

  if ((DIV & (DIV - 1)) == 0) begin : g_pow2
    logic          done_q;
    logic [RW-1:0] rem_q;

    // The remainder is the low bits of the value.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else if (start_i) begin
        done_q <= 1'b1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        rem_q <= (DIV > 1) ? value_i[RW-1:0] : '0;
      end
    end

    assign done_o = done_q;
    assign rem_o  = rem_q;
  end else begin : g_recip
    localparam int unsigned SH = W + RW;
    localparam int unsigned PW = SH + W;
    localparam logic [63:0] RECIP = ((64'd1 << SH) + 64'(DIV) - 64'd1) / 64'(DIV);
    localparam logic [W-1:0] DIV_W = W'(DIV);

    logic          mul_q, sub_q, done_q;
    logic [W-1:0]  val_q, quot_q, diff;
    logic [PW-1:0] prod;
    logic [RW-1:0] rem_q;

    // The quotient is the value times the rounded-up reciprocal, shifted down;
    // the remainder is what the quotient times the divisor leaves of the value.
    always_comb begin
      prod = PW'(val_q) * PW'(RECIP);
      diff = val_q - quot_q * DIV_W;
    end

    // Registered steps: the multiply, then the subtract.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mul_q  <= 1'b0;
        sub_q  <= 1'b0;
        done_q <= 1'b0;
      end else if (start_i) begin
        mul_q  <= 1'b1;
        sub_q  <= 1'b0;
        done_q <= 1'b0;
      end else begin
        mul_q <= 1'b0;
        sub_q <= mul_q;
        if (sub_q) begin
          done_q <= 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        val_q <= value_i;
      end
      if (mul_q) begin
        quot_q <= prod[SH +: W];
      end
      if (sub_q) begin
        rem_q <= diff[RW-1:0];
      end
    end

    assign done_o = done_q;
    assign rem_o  = rem_q;
  end

endmodule

>>> design/sawbc_dp.sv
// Datapath of the cache: line data, tag and state memories, victim LFSR, output register.
// Depends on sawbc_pkg and sawbc_mod.
module sawbc_dp #(
  parameter int unsigned SETS = 64,
  parameter int unsigned WAYS = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sawbc_pkg::cmd_t       cmd_i,
  output sawbc_pkg::sts_t       sts_o,
  input  sawbc_pkg::cache_in_t  in_data_i,
  input  logic                  cfg_we_i,
  input  logic [15:0]           cfg_wdata_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output sawbc_pkg::cache_out_t out_data_o
);
  import sawbc_pkg::*;

  localparam int unsigned SW = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned AW = SW + WW + WORD_IDX_W;

  // Captured access and fill word.
  logic [1:0]       acc_cmd_q;
  logic [31:0]      acc_addr_q, acc_wdata_q, acc_wmask_q, fill_q;
  logic [BLK_W-1:0] acc_blk;
  logic [3:0]       acc_widx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture_acc) begin
      acc_cmd_q   <= in_data_i.command;
      acc_addr_q  <= in_data_i.address;
      acc_wdata_q <= in_data_i.write_data;
      acc_wmask_q <= in_data_i.write_mask;
    end
    if (cmd_i.capture_fill) begin
      fill_q <= in_data_i.fill_data;
    end
  end

  assign acc_blk  = acc_addr_q[31:BLK_LSB];
  assign acc_widx = acc_addr_q[BLK_LSB-1:WORD_LSB];

  // Set index from the block number.
  logic          set_done;
  logic [SW-1:0] set_idx;

  sawbc_mod #(.W(BLK_W), .DIV(SETS), .RW(SW)) u_set_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.set_start),
    .value_i (in_data_i.address[31:BLK_LSB]),
    .done_o  (set_done),
    .rem_o   (set_idx)
  );

  // Victim selector LFSR.
  logic [15:0]   lfsr_q;
  logic          vmod_done;
  logic [WW-1:0] vmod_rem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lfsr_q <= SEED_RESET;
    end else if (cfg_we_i) begin
      lfsr_q <= cfg_wdata_i;
    end else if (cmd_i.vmod_start) begin
      lfsr_q <= lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
    end
  end

  sawbc_mod #(.W(16), .DIV(WAYS), .RW(WW)) u_way_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.vmod_start),
    .value_i (lfsr_q),
    .done_o  (vmod_done),
    .rem_o   (vmod_rem)
  );

  // Control counters and the fill flag.
  logic [SW-1:0] clear_cnt_q;
  logic [3:0]    wb_cnt_q, fill_cnt_q;
  logic          awaiting_q;
  logic [WW-1:0] way_q;
  logic [WW-1:0] hit_way, first_inv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_cnt_q <= '0;
      wb_cnt_q    <= '0;
      fill_cnt_q  <= '0;
      awaiting_q  <= 1'b0;
    end else begin
      if (cmd_i.clear_step) begin
        clear_cnt_q <= clear_cnt_q + 1'b1;
      end
      if (cmd_i.take_inv || cmd_i.take_mod) begin
        wb_cnt_q <= '0;
      end else if (cmd_i.wb_inc) begin
        wb_cnt_q <= wb_cnt_q + 1'b1;
      end
      if (cmd_i.start_fill) begin
        awaiting_q <= 1'b1;
        fill_cnt_q <= '0;
      end else if (cmd_i.end_fill) begin
        awaiting_q <= 1'b0;
        fill_cnt_q <= '0;
      end else if (cmd_i.fill_inc) begin
        fill_cnt_q <= fill_cnt_q + 1'b1;
      end
    end
  end

  // Way of the current access: hit way, first invalid way or random victim.
  always_ff @(posedge clk_i) begin
    if (cmd_i.data_rd_hit) begin
      way_q <= hit_way;
    end else if (cmd_i.take_inv) begin
      way_q <= first_inv;
    end else if (cmd_i.take_mod) begin
      way_q <= vmod_rem;
    end
  end

  // Tag and state memories, one row per set.
  logic [WAYS-1:0]            valid_mem [SETS];
  logic [WAYS-1:0]            dirty_mem [SETS];
  logic [WAYS-1:0][BLK_W-1:0] tag_mem   [SETS];
  logic [WAYS-1:0]            valid_row_q, dirty_row_q, valid_row_d, dirty_row_d, way_bit;
  logic [WAYS-1:0][BLK_W-1:0] tag_row_q, tag_row_d;
  logic [SW-1:0]              meta_addr;
  logic                       meta_we;

  always_comb begin
    way_bit     = '0;
    way_bit[way_q] = 1'b1;
    valid_row_d = valid_row_q;
    dirty_row_d = dirty_row_q;
    tag_row_d   = tag_row_q;
    meta_addr   = set_idx;
    if (cmd_i.clear_step) begin
      valid_row_d = '0;
      dirty_row_d = '0;
      tag_row_d   = '0;
      meta_addr   = clear_cnt_q;
    end else if (cmd_i.meta_wr_evict) begin
      valid_row_d = valid_row_q & ~way_bit;
      dirty_row_d = dirty_row_q & ~way_bit;
    end else if (cmd_i.meta_wr_dirty) begin
      dirty_row_d = dirty_row_q | way_bit;
    end else if (cmd_i.meta_wr_fill) begin
      valid_row_d = valid_row_q | way_bit;
      dirty_row_d = (acc_cmd_q == CMD_WRITE) ? (dirty_row_q | way_bit)
                                             : (dirty_row_q & ~way_bit);
      tag_row_d[way_q] = acc_blk;
    end
  end

  assign meta_we = cmd_i.clear_step | cmd_i.meta_wr_evict | cmd_i.meta_wr_dirty |
                   cmd_i.meta_wr_fill;

  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      valid_mem[meta_addr] <= valid_row_d;
      dirty_mem[meta_addr] <= dirty_row_d;
      tag_mem[meta_addr]   <= tag_row_d;
    end
    if (cmd_i.meta_rd) begin
      valid_row_q <= valid_mem[set_idx];
      dirty_row_q <= dirty_mem[set_idx];
      tag_row_q   <= tag_mem[set_idx];
    end
  end

  // Tag compare and victim search across the ways of the row.
  logic [WAYS-1:0] hit_vec;

  always_comb begin
    hit_way   = '0;
    first_inv = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = valid_row_q[w] && (tag_row_q[w] == acc_blk);
      if (hit_vec[w]) begin
        hit_way = WW'(w);
      end
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (!valid_row_q[w]) begin
        first_inv = WW'(w);
      end
    end
  end

  // Line data memory, addressed by set, way and word.
  logic [31:0]   data_mem [2**AW];
  logic [31:0]   rdata_q, wdata;
  logic [AW-1:0] waddr, raddr;
  logic          data_we, data_re;

  always_comb begin
    if (cmd_i.data_wr_fill) begin
      waddr = {set_idx, way_q, fill_cnt_q};
      wdata = fill_q;
    end else begin
      waddr = {set_idx, way_q, acc_widx};
      wdata = (rdata_q & ~acc_wmask_q) | (acc_wdata_q & acc_wmask_q);
    end
    if (cmd_i.data_rd_hit) begin
      raddr = {set_idx, hit_way, acc_widx};
    end else if (cmd_i.data_rd_wb) begin
      raddr = {set_idx, way_q, wb_cnt_q};
    end else begin
      raddr = {set_idx, way_q, acc_widx};
    end
  end

  assign data_we = cmd_i.data_wr_fill | cmd_i.data_wr_merge;
  assign data_re = cmd_i.data_rd_hit | cmd_i.data_rd_wb | cmd_i.data_rd_pend;

  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[waddr] <= wdata;
    end
    if (data_re) begin
      rdata_q <= data_mem[raddr];
    end
  end

  // Output register.
  logic       out_valid_q;
  cache_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit != EMIT_NONE) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit != EMIT_NONE) begin
      out_q.data         <= '0;
      out_q.block_number <= '0;
      out_q.word_index   <= '0;
      out_q.last         <= 1'b1;
      unique case (cmd_i.emit)
        EMIT_READ: begin
          out_q.kind <= KIND_READ;
          out_q.data <= rdata_q;
        end
        EMIT_WDONE: begin
          out_q.kind <= KIND_WDONE;
        end
        EMIT_WB: begin
          out_q.kind         <= KIND_WB;
          out_q.data         <= rdata_q;
          out_q.block_number <= tag_row_q[way_q];
          out_q.word_index   <= wb_cnt_q;
          out_q.last         <= 1'b0;
        end
        EMIT_FREQ: begin
          out_q.kind         <= KIND_FREQ;
          out_q.block_number <= acc_blk;
        end
        default: begin
          out_q.kind <= KIND_READ;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Status toward the controller.
  always_comb begin
    sts_o.in_access    = (in_data_i.command == CMD_READ) || (in_data_i.command == CMD_WRITE);
    sts_o.in_fill      = (in_data_i.command == CMD_FILL);
    sts_o.awaiting     = awaiting_q;
    sts_o.set_done     = set_done;
    sts_o.vmod_done    = vmod_done;
    sts_o.hit          = |hit_vec;
    sts_o.any_invalid  = ~&valid_row_q;
    sts_o.victim_dirty = valid_row_q[way_q] & dirty_row_q[way_q];
    sts_o.wb_last      = (wb_cnt_q == 4'(WORDS_PER_LINE - 1));
    sts_o.fill_last    = (fill_cnt_q == 4'(WORDS_PER_LINE - 1));
    sts_o.clear_last   = (clear_cnt_q == SW'(SETS - 1));
    sts_o.out_free     = !out_valid_q || !out_stall_i;
    sts_o.acc_write    = (acc_cmd_q == CMD_WRITE);
  end

endmodule

>>> design/sawbc_ctrl.sv
// Controller state machine of the cache: sequences lookups, evictions and line fills.
// Depends on sawbc_pkg; drives the datapath only through cmd_t and reads sts_t.
module sawbc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  sawbc_pkg::sts_t sts_i,
  output sawbc_pkg::cmd_t cmd_o
);
  import sawbc_pkg::*;

  typedef enum logic [12:0] {
    S_CLEAR     = 13'b0000000000001,
    S_IDLE      = 13'b0000000000010,
    S_SETMOD    = 13'b0000000000100,
    S_LOOK      = 13'b0000000001000,
    S_VMOD      = 13'b0000000010000,
    S_VIC       = 13'b0000000100000,
    S_WB_RD     = 13'b0000001000000,
    S_WB_OUT    = 13'b0000010000000,
    S_EVICT     = 13'b0000100000000,
    S_HIT       = 13'b0001000000000,
    S_FILL_WR   = 13'b0010000000000,
    S_FILL_META = 13'b0100000000000,
    S_FILL_DONE = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != S_IDLE);
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (sts_i.clear_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (sts_i.in_access && !sts_i.awaiting) begin
            cmd_o.capture_acc = 1'b1;
            cmd_o.set_start   = 1'b1;
            state_d           = S_SETMOD;
          end else if (sts_i.in_fill && sts_i.awaiting) begin
            cmd_o.capture_fill = 1'b1;
            state_d            = S_FILL_WR;
          end
        end
      end
      S_SETMOD: begin
        if (sts_i.set_done) begin
          cmd_o.meta_rd = 1'b1;
          state_d       = S_LOOK;
        end
      end
      S_LOOK: begin
        if (sts_i.hit) begin
          cmd_o.data_rd_hit = 1'b1;
          state_d           = S_HIT;
        end else if (sts_i.any_invalid) begin
          cmd_o.take_inv = 1'b1;
          state_d        = S_VIC;
        end else begin
          cmd_o.vmod_start = 1'b1;
          state_d          = S_VMOD;
        end
      end
      S_VMOD: begin
        if (sts_i.vmod_done) begin
          cmd_o.take_mod = 1'b1;
          state_d        = S_VIC;
        end
      end
      S_VIC: begin
        state_d = sts_i.victim_dirty ? S_WB_RD : S_EVICT;
      end
      S_WB_RD: begin
        cmd_o.data_rd_wb = 1'b1;
        state_d          = S_WB_OUT;
      end
      S_WB_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = EMIT_WB;
          if (sts_i.wb_last) begin
            state_d = S_EVICT;
          end else begin
            cmd_o.wb_inc = 1'b1;
            state_d      = S_WB_RD;
          end
        end
      end
      S_EVICT: begin
        if (sts_i.out_free) begin
          cmd_o.meta_wr_evict = 1'b1;
          cmd_o.start_fill    = 1'b1;
          cmd_o.emit          = EMIT_FREQ;
          state_d             = S_IDLE;
        end
      end
      S_HIT: begin
        if (sts_i.out_free) begin
          if (sts_i.acc_write) begin
            cmd_o.data_wr_merge = 1'b1;
            cmd_o.meta_wr_dirty = 1'b1;
            cmd_o.emit          = EMIT_WDONE;
          end else begin
            cmd_o.emit = EMIT_READ;
          end
          state_d = S_IDLE;
        end
      end
      S_FILL_WR: begin
        cmd_o.data_wr_fill = 1'b1;
        if (sts_i.fill_last) begin
          cmd_o.meta_rd = 1'b1;
          state_d       = S_FILL_META;
        end else begin
          cmd_o.fill_inc = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_FILL_META: begin
        cmd_o.meta_wr_fill = 1'b1;
        cmd_o.data_rd_pend = 1'b1;
        state_d            = S_FILL_DONE;
      end
      S_FILL_DONE: begin
        if (sts_i.out_free) begin
          if (sts_i.acc_write) begin
            cmd_o.data_wr_merge = 1'b1;
            cmd_o.emit          = EMIT_WDONE;
          end else begin
            cmd_o.emit = EMIT_READ;
          end
          cmd_o.end_fill = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule
